// ===== sv/greedy_first_fit_vertex_coloring_assert.svh =====
// assertion helpers for the coloring block
`ifndef GREEDY_FIRST_FIT_VERTEX_COLORING_ASSERT_SVH
`define GREEDY_FIRST_FIT_VERTEX_COLORING_ASSERT_SVH

// same-cycle implication
`define GFFVC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication after a fixed number of cycles
`define GFFVC_ASSERT_DELAY(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

// ===== sv/gffvc_pkg.sv =====
package gffvc_pkg;

   localparam int ID_W             = 14;
   localparam int COLOR_W          = 8;
   localparam int NUM_VERTICES_DEF = 16384;
   localparam int NUM_COLORS_DEF   = 128;

   // marker for a vertex that holds no color yet
   localparam logic [COLOR_W-1:0] UNCOLORED = 8'hFF;

   typedef struct packed {
      logic [ID_W-1:0] vertex;
      logic [ID_W-1:0] neighbor;
      logic            has_neighbor;
      logic            last;
   } req_payload_type;

   typedef struct packed {
      logic [ID_W-1:0]    colored_vertex;
      logic [COLOR_W-1:0] color;
      logic               palette_full;
   } rsp_payload_type;

endpackage

// ===== sv/greedy_first_fit_vertex_coloring.sv =====
// channel   | ports                          | handshake
// ----------+--------------------------------+-----------------------------------
// request   | start, busy, req_item          | transfer when start && !busy
// response  | rsp_valid, rsp_item            | one-cycle strobe, no back pressure
//
// a neighbor-only item does not raise busy; an item with last set holds busy while
// it sits in the mark stage; the color search and table write-back follow it
// the color table is one memory with a registered read port
// after reset a clearing pass writes the uncolored marker to every entry;
// busy stays high until the pass completes
// the response side cannot stall; results pass the mark, search and response registers
module greedy_first_fit_vertex_coloring
   import gffvc_pkg::*;
#(
   parameter int NUM_VERTICES = NUM_VERTICES_DEF,
   parameter int NUM_COLORS   = NUM_COLORS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_item,
   output logic            rsp_valid,
   output rsp_payload_type rsp_item
);

   localparam int AW = $clog2(NUM_VERTICES);
   // compare width: holds any id and NUM_VERTICES itself
   localparam int CW = ((AW > ID_W) ? AW : ID_W) + 1;

   // color table
   logic [COLOR_W-1:0] color_mem [NUM_VERTICES];

   // clearing pass
   logic          clearing_ff;
   logic [AW-1:0] clr_addr_ff;

   // read stage
   logic               accept;
   logic [CW-1:0]      nb_wide;
   logic               nb_ok;
   logic [AW-1:0]      rd_addr;
   logic [COLOR_W-1:0] rd_data_ff;
   logic               fwd_hit_ff;
   logic [COLOR_W-1:0] fwd_data_ff;

   // mark stage
   logic               s1_mark_ff;
   logic               s1_last_ff;
   logic [ID_W-1:0]    s1_vertex_ff;
   logic [COLOR_W-1:0] s1_color;
   logic [NUM_COLORS:0] mark;
   logic [NUM_COLORS:0] used_ff;
   logic [NUM_COLORS:0] used_in;

   // search and write-back stage
   logic               s2_valid_ff;
   logic [ID_W-1:0]    s2_vertex_ff;
   logic [CW-1:0]      v_wide;
   logic               v_ok;
   logic [COLOR_W-1:0] pick;

   // table write port
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [COLOR_W-1:0] wr_data;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_item_ff;

   // a last item blocks only its mark cycle; the write-back overlaps the next
   // transfer and is forwarded into that read
   assign busy   = clearing_ff || s1_last_ff;
   assign accept = start && !busy;

   assign nb_wide = CW'(req_item.neighbor);
   assign nb_ok   = nb_wide < CW'(NUM_VERTICES);
   assign rd_addr = nb_wide[AW-1:0];

   // ---------------- clearing pass ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(NUM_VERTICES - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // ---------------- memory ----------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         color_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= color_mem[rd_addr];
   end

   // read and write on the same edge: take the value being written
   always_ff @(posedge clock) begin
      fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
      fwd_data_ff <= wr_data;
   end

   // ---------------- read stage -> mark stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_mark_ff <= 1'b0;
         s1_last_ff <= 1'b0;
      end else begin
         s1_mark_ff <= accept && req_item.has_neighbor && nb_ok;
         s1_last_ff <= accept && req_item.last;
      end
      s1_vertex_ff <= req_item.vertex;
   end

   assign s1_color = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

   // an uncolored marker decodes to nothing, since it lies above NUM_COLORS
   always_comb begin
      for (int i = 0; i <= NUM_COLORS; i++) begin
         mark[i] = s1_mark_ff && (s1_color == COLOR_W'(i));
      end
   end

   // bitmap clears on the write-back edge; the next vertex marks at the edge after it
   always_comb begin
      if (s2_valid_ff) begin
         used_in = '0;
      end else begin
         used_in = used_ff | mark;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // ---------------- search and write-back ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_last_ff;
      end
      s2_vertex_ff <= s1_vertex_ff;
   end

   // lowest free color; the exhausted slot never blocks
   always_comb begin
      pick = COLOR_W'(NUM_COLORS);
      for (int i = NUM_COLORS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            pick = COLOR_W'(i);
         end
      end
   end

   assign v_wide = CW'(s2_vertex_ff);
   assign v_ok   = v_wide < CW'(NUM_VERTICES);

   always_comb begin
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = UNCOLORED;
      end else begin
         wr_en   = s2_valid_ff && v_ok;
         wr_addr = v_wide[AW-1:0];
         wr_data = pick;
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (s2_valid_ff) begin
         rsp_item_ff.colored_vertex <= s2_vertex_ff;
         rsp_item_ff.color          <= pick;
         rsp_item_ff.palette_full   <= (pick == COLOR_W'(NUM_COLORS));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---------------- assertions ----------------
`include "greedy_first_fit_vertex_coloring_assert.svh"

   // strobe is sampled once the item has passed the mark, search and response registers
   `GFFVC_ASSERT_DELAY(a_last_gives_result, clock, reset, accept && req_item.last, 3,
                       rsp_valid, "last transfer without result")
   `GFFVC_ASSERT_NOW(a_bitmap_cleared, clock, reset, rsp_valid, used_ff == '0,
                     "bitmap not cleared after result")
   `GFFVC_ASSERT_NOW(a_full_flag, clock, reset, rsp_valid,
                     rsp_item.palette_full == (rsp_item.color == COLOR_W'(NUM_COLORS)),
                     "full flag disagrees with color")
   `GFFVC_ASSERT_NOW(a_no_write_clash, clock, reset, clearing_ff, !s2_valid_ff && !s1_last_ff,
                     "item in flight during clearing pass")

endmodule
